[hw/rtl/sdp_pkg.sv]
// ----------------------------------------------------------------------------
// sdp_pkg: shared types and constants of the saturating decimal parser
// Holds the parse job passed from the front end to the back end, the
// character codes, the saturation bounds and the shared multiply-by-ten.
// ----------------------------------------------------------------------------
package sdp_pkg;

    // Number of finished strings the queue between front and back can hold.
    localparam int QUEUE_DEPTH = 2;

    // Character codes.
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_E     = 8'h65;

    // Keyword lengths.
    localparam logic [2:0] KW_TRUE_LEN  = 3'd4;
    localparam logic [2:0] KW_FALSE_LEN = 3'd5;
    localparam logic [2:0] KW_LEN_MAX   = 3'd7;

    // Saturation bounds.
    localparam logic [63:0] BOUND         = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TIMES10_LIMIT = 64'h0CCC_CCCC_CCCC_CCCC;
    localparam logic [63:0] INT64_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] INT32_MIN     = 64'hFFFF_FFFF_8000_0000;
    localparam logic [63:0] INT32_MAX     = 64'h0000_0000_7FFF_FFFF;

    // Most exponent steps ever applied.
    localparam logic [3:0] EXP_MAX = 4'd10;

    // One finished string, ready for scaling and clamping.
    typedef struct packed {
        logic        ok;
        logic        negative;
        logic [63:0] mantissa;
        logic [3:0]  exponent;
    } job_t;

    // Multiply by ten, saturating at 2^63.
    function automatic logic [63:0] sat_times10(input logic [63:0] x);
        logic [63:0] prod;
        begin
            prod = (x << 3) + (x << 1);
            return (x > TIMES10_LIMIT) ? BOUND : prod;
        end
    endfunction

    // Expected character of "true" at a given position.
    function automatic logic [7:0] kw_true_char(input logic [1:0] pos);
        logic [7:0] ch;
        begin
            unique case (pos)
                2'd0:    ch = 8'h74;
                2'd1:    ch = 8'h72;
                2'd2:    ch = 8'h75;
                default: ch = 8'h65;
            endcase
            return ch;
        end
    endfunction

    // Expected character of "false" at a given position (positions 0 to 4).
    function automatic logic [7:0] kw_false_char(input logic [2:0] pos);
        logic [7:0] ch;
        begin
            unique case (pos)
                3'd0:    ch = 8'h66;
                3'd1:    ch = 8'h61;
                3'd2:    ch = 8'h6C;
                3'd3:    ch = 8'h73;
                3'd4:    ch = 8'h65;
                default: ch = 8'h00;
            endcase
            return ch;
        end
    endfunction

endpackage

[hw/rtl/sdp_front.sv]
// ----------------------------------------------------------------------------
// sdp_front: character front end
// Takes one character per beat, tracks the parse phase, sign, saturating
// mantissa, exponent and keyword matching, and on NUL hands a job to the queue.
// ----------------------------------------------------------------------------
module sdp_front
    import sdp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_code
    output logic       push_valid,
    output job_t       push_job,
    input  logic       push_ready
);

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_SIGNED = 5'b00010,
        PH_MANT   = 5'b00100,
        PH_EXPO   = 5'b01000,
        PH_BAD    = 5'b10000
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic        negative_reg, negative_next;
    logic [63:0] mantissa_reg, mantissa_next;
    logic [3:0]  exponent_reg, exponent_next;
    logic [2:0]  kw_len_reg,   kw_len_next;
    logic        t_live_reg,   t_live_next;
    logic        f_live_reg,   f_live_next;

    logic        accept;
    logic        is_nul;
    logic        is_digit;
    logic [3:0]  digit;
    logic [7:0]  digit_wide;
    logic [63:0] mant_x10;
    logic [64:0] mant_sum;
    logic [63:0] mant_acc;

    // A beat is taken only when the queue can hold a possible result.
    assign s_tready = push_ready;
    assign accept   = s_tvalid && s_tready;
    assign is_nul   = (s_tdata == CHAR_NUL);

    // Digit decode and the saturating mantissa accumulate.
    assign is_digit   = (s_tdata >= CHAR_ZERO) && (s_tdata <= CHAR_NINE);
    assign digit_wide = s_tdata - CHAR_ZERO;
    assign digit      = digit_wide[3:0];
    assign mant_x10   = sat_times10(mantissa_reg);
    assign mant_sum   = {1'b0, mant_x10} + {61'd0, digit};
    assign mant_acc   = (mant_sum > {1'b0, BOUND}) ? BOUND : mant_sum[63:0];

    // Job built from the state at the terminator.
    always_comb
    begin
        push_valid = accept && is_nul;
        push_job   = '0;
        if (t_live_reg && (kw_len_reg == KW_TRUE_LEN))
        begin
            push_job.ok       = 1'b1;
            push_job.mantissa = 64'd1;
        end
        else if (f_live_reg && (kw_len_reg == KW_FALSE_LEN))
        begin
            push_job.ok = 1'b1;
        end
        else if ((phase_reg == PH_MANT) || (phase_reg == PH_EXPO))
        begin
            push_job.ok       = 1'b1;
            push_job.negative = negative_reg;
            push_job.mantissa = mantissa_reg;
            push_job.exponent = exponent_reg;
        end
    end

    // Next parse state for one character.
    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        mantissa_next = mantissa_reg;
        exponent_next = exponent_reg;
        kw_len_next   = kw_len_reg;
        t_live_next   = t_live_reg;
        f_live_next   = f_live_reg;
        if (accept)
        begin
            if (is_nul)
            begin
                phase_next    = PH_START;
                negative_next = 1'b0;
                mantissa_next = '0;
                exponent_next = '0;
                kw_len_next   = '0;
                t_live_next   = 1'b1;
                f_live_next   = 1'b1;
            end
            else
            begin
                // Keyword tracking.
                if ((kw_len_reg >= KW_TRUE_LEN) || (kw_true_char(kw_len_reg[1:0]) != s_tdata))
                begin
                    t_live_next = 1'b0;
                end
                if ((kw_len_reg >= KW_FALSE_LEN) || (kw_false_char(kw_len_reg) != s_tdata))
                begin
                    f_live_next = 1'b0;
                end
                if (kw_len_reg < KW_LEN_MAX)
                begin
                    kw_len_next = kw_len_reg + 3'd1;
                end

                // Number syntax.
                unique case (phase_reg)
                    PH_START, PH_SIGNED:
                    begin
                        if ((phase_reg == PH_START) && (s_tdata == CHAR_MINUS))
                        begin
                            negative_next = 1'b1;
                            phase_next    = PH_SIGNED;
                        end
                        else if (is_digit)
                        begin
                            mantissa_next = {60'd0, digit};
                            phase_next    = PH_MANT;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_MANT:
                    begin
                        if (is_digit)
                        begin
                            mantissa_next = mant_acc;
                        end
                        else if (s_tdata == CHAR_E)
                        begin
                            phase_next = PH_EXPO;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    PH_EXPO:
                    begin
                        if (is_digit)
                        begin
                            exponent_next = (exponent_reg != 4'd0) ? EXP_MAX : digit;
                        end
                        else
                        begin
                            phase_next = PH_BAD;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_BAD;
                    end
                endcase
            end
        end
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_START;
            negative_reg <= 1'b0;
            mantissa_reg <= '0;
            exponent_reg <= '0;
            kw_len_reg   <= '0;
            t_live_reg   <= 1'b1;
            f_live_reg   <= 1'b1;
        end
        else
        begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            mantissa_reg <= mantissa_next;
            exponent_reg <= exponent_next;
            kw_len_reg   <= kw_len_next;
            t_live_reg   <= t_live_next;
            f_live_reg   <= f_live_next;
        end
    end

endmodule

[hw/rtl/sdp_queue.sv]
// ----------------------------------------------------------------------------
// sdp_queue: job queue between front and back end
// A short first-in first-out queue of finished strings, so the front end
// keeps taking characters while the back end scales a value.
// ----------------------------------------------------------------------------
module sdp_queue
    import sdp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    input  job_t push_job,
    output logic push_ready,
    output logic pop_valid,
    output job_t pop_job,
    input  logic pop_ready
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != DEPTH_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[hw/rtl/sdp_back.sv]
// ----------------------------------------------------------------------------
// sdp_back: scaling and clamping back end
// Pops a job, multiplies the mantissa by ten once per exponent step with
// saturation, applies the sign and the int64 or int32 clamp, and holds the
// result in the output register until it is taken.
// ----------------------------------------------------------------------------
module sdp_back
    import sdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        narrow_to_32,
    input  logic        pop_valid,
    input  job_t        pop_job,
    output logic        pop_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [0:0]  m_tuser    // [0] ok
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_SCALE = 3'b010,
        B_OUT   = 3'b100
    } bstate_t;

    bstate_t     state_reg, state_next;
    logic        ok_reg,    ok_next;
    logic        neg_reg,   neg_next;
    logic [63:0] val_reg,   val_next;
    logic [3:0]  cnt_reg,   cnt_next;
    logic        out_ok_reg,  out_ok_next;
    logic [63:0] out_val_reg, out_val_next;

    logic [63:0] signed_val;
    logic [63:0] final_val;

    assign pop_ready = (state_reg == B_IDLE);
    assign m_tvalid  = (state_reg == B_OUT);
    assign m_tdata   = out_val_reg;
    assign m_tuser   = out_ok_reg;

    // Sign and range clamp of the scaled magnitude.
    always_comb
    begin
        if (neg_reg)
        begin
            signed_val = (val_reg >= BOUND) ? BOUND : (64'd0 - val_reg);
        end
        else
        begin
            signed_val = (val_reg >= BOUND) ? INT64_MAX : val_reg;
        end
        final_val = signed_val;
        if (narrow_to_32)
        begin
            if (signed_val[63] && (signed_val < INT32_MIN))
            begin
                final_val = INT32_MIN;
            end
            else if (!signed_val[63] && (signed_val > INT32_MAX))
            begin
                final_val = INT32_MAX;
            end
        end
    end

    // Sequencer: load, one multiply-by-ten per cycle, then present.
    always_comb
    begin
        state_next   = state_reg;
        ok_next      = ok_reg;
        neg_next     = neg_reg;
        val_next     = val_reg;
        cnt_next     = cnt_reg;
        out_ok_next  = out_ok_reg;
        out_val_next = out_val_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (pop_valid)
                begin
                    ok_next    = pop_job.ok;
                    neg_next   = pop_job.negative;
                    val_next   = pop_job.mantissa;
                    cnt_next   = (pop_job.exponent > EXP_MAX) ? EXP_MAX : pop_job.exponent;
                    state_next = B_SCALE;
                end
            end
            B_SCALE:
            begin
                if (cnt_reg != 4'd0)
                begin
                    val_next = sat_times10(val_reg);
                    cnt_next = cnt_reg - 4'd1;
                end
                else
                begin
                    out_ok_next  = ok_reg;
                    out_val_next = final_val;
                    state_next   = B_OUT;
                end
            end
            B_OUT:
            begin
                if (m_tready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Working and output payload registers.
    always_ff @(posedge clk)
    begin
        ok_reg      <= ok_next;
        neg_reg     <= neg_next;
        val_reg     <= val_next;
        out_ok_reg  <= out_ok_next;
        out_val_reg <= out_val_next;
    end

endmodule

[hw/rtl/saturating_decimal_parser_core.sv]
// ----------------------------------------------------------------------------
// saturating_decimal_parser_core: streaming decimal string to int64 parser
// Throughput: one character beat per cycle; the front end stalls only when
// the two-entry job queue is full. A NUL beat's job goes through the queue
// to the back end, which applies E = min(exponent, 10) steps of the shared
// multiply-by-ten before the result is valid, one string at a time.
// Reset (rst_n, asynchronous, active low) clears the parse state, the queue,
// the back end sequencer and narrow_to_32.
// ----------------------------------------------------------------------------
module saturating_decimal_parser_core
    import sdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value
    output logic [0:0]  m_tuser,   // [0] ok
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data   // narrow_to_32
);

    logic narrow_reg;
    logic push_valid;
    job_t push_job;
    logic push_ready;
    logic pop_valid;
    job_t pop_job;
    logic pop_ready;

    // Configuration register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            narrow_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            narrow_reg <= cfg_data;
        end
    end

    sdp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready)
    );

    sdp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_job   (push_job),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_job    (pop_job),
        .pop_ready  (pop_ready)
    );

    sdp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .narrow_to_32 (narrow_reg),
        .pop_valid    (pop_valid),
        .pop_job      (pop_job),
        .pop_ready    (pop_ready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

[tb/sv/saturating_decimal_parser_monitor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_decimal_parser_monitor: result checker for the decimal parser
// Watches the character, result and configuration channels of the parser.
// It keeps its own copy of the parse state and of narrow_to_32, predicts
// the number that each terminated string should give, and compares every
// result beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module saturating_decimal_parser_monitor
    import sdp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,   // [63:0] value
    input  logic [0:0]  m_tuser,   // [0] ok
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,  // narrow_to_32
    output int          open_results,
    output int          error_count
);

    // Mismatches beyond this count are still counted but no longer printed.
    localparam int REPORT_LIMIT = 40;

    localparam logic [31:0] TRUE_WORD  = "true";
    localparam logic [39:0] FALSE_WORD = "false";

    typedef enum logic [2:0] {
        SCAN_START,
        SCAN_SIGNED,
        SCAN_MANT,
        SCAN_EXP,
        SCAN_BAD
    } scan_phase_t;

    typedef struct packed {
        logic        ok;
        logic [63:0] value;
    } parsed_number_t;

    // Shadow of the parser state.
    logic        narrow;
    scan_phase_t scan_phase;
    logic        minus_seen;
    logic [63:0] mantissa;
    logic [3:0]  exponent;
    logic [2:0]  word_len;
    logic        true_live;
    logic        false_live;

    parsed_number_t expected_numbers[$];

    // Multiply by ten, saturating at 2^63.
    function automatic logic [63:0] scale_by_ten(input logic [63:0] x);
        begin
            return (x > (BOUND / 64'd10)) ? BOUND : x * 64'd10;
        end
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        begin
            return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        end
    endfunction

    task automatic clear_scan();
        begin
            scan_phase = SCAN_START;
            minus_seen = 1'b0;
            mantissa   = '0;
            exponent   = '0;
            word_len   = '0;
            true_live  = 1'b1;
            false_live = 1'b1;
        end
    endtask

    // Advance the keyword match and the number scan by one character.
    task automatic take_char(input logic [7:0] c);
        logic [63:0] digit;
        begin
            digit = {56'd0, c - CHAR_ZERO};
            if (word_len >= KW_TRUE_LEN || TRUE_WORD[8 * (3 - word_len) +: 8] != c)
                true_live = 1'b0;
            if (word_len >= KW_FALSE_LEN || FALSE_WORD[8 * (4 - word_len) +: 8] != c)
                false_live = 1'b0;
            if (word_len < KW_LEN_MAX)
                word_len = word_len + 3'd1;

            if (scan_phase == SCAN_START && c == CHAR_MINUS)
            begin
                minus_seen = 1'b1;
                scan_phase = SCAN_SIGNED;
            end
            else if (scan_phase == SCAN_START || scan_phase == SCAN_SIGNED)
            begin
                if (is_digit(c))
                begin
                    mantissa   = digit;
                    scan_phase = SCAN_MANT;
                end
                else
                    scan_phase = SCAN_BAD;
            end
            else if (scan_phase == SCAN_MANT)
            begin
                if (is_digit(c))
                begin
                    mantissa = scale_by_ten(mantissa);
                    mantissa = (BOUND - digit < mantissa) ? BOUND : mantissa + digit;
                end
                else if (c == CHAR_E)
                    scan_phase = SCAN_EXP;
                else
                    scan_phase = SCAN_BAD;
            end
            else if (scan_phase == SCAN_EXP)
            begin
                if (is_digit(c))
                    exponent = (exponent != 4'd0) ? EXP_MAX : digit[3:0];
                else
                    scan_phase = SCAN_BAD;
            end
            else
                scan_phase = SCAN_BAD;
        end
    endtask

    // The number that the terminator of the current string produces.
    function automatic parsed_number_t close_string();
        parsed_number_t num;
        logic [63:0]    v;
        int             i;
        begin
            num.ok    = 1'b0;
            num.value = '0;
            if (true_live && word_len == KW_TRUE_LEN)
            begin
                num.ok    = 1'b1;
                num.value = 64'd1;
            end
            else if (false_live && word_len == KW_FALSE_LEN)
                num.ok = 1'b1;
            else if (scan_phase == SCAN_MANT || scan_phase == SCAN_EXP)
            begin
                v = mantissa;
                for (i = 0; i < exponent && i < EXP_MAX; i++)
                    v = scale_by_ten(v);
                if (minus_seen)
                    v = (v >= BOUND) ? BOUND : 64'd0 - v;
                else
                    v = (v >= BOUND) ? INT64_MAX : v;
                // Optional clamp to the 32-bit signed range.
                if (narrow)
                begin
                    if (v[63] && v < INT32_MIN)
                        v = INT32_MIN;
                    else if (!v[63] && v > INT32_MAX)
                        v = INT32_MAX;
                end
                num.ok    = 1'b1;
                num.value = v;
            end
            return num;
        end
    endfunction

    // Sample all three channels at the clock edge and keep the prediction.
    always @(posedge clk or negedge rst_n)
    begin : watch
        parsed_number_t want;
        if (!rst_n)
        begin
            narrow = 1'b0;
            clear_scan();
            expected_numbers.delete();
            open_results <= 0;
            error_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                narrow = cfg_data;

            // Compare a result beat against the oldest prediction.
            if (m_tvalid && m_tready)
            begin
                if (expected_numbers.size() == 0)
                begin
                    if (error_count < REPORT_LIMIT)
                        $error("result beat with no string pending: ok %0d value %0d",
                               m_tuser[0], $signed(m_tdata));
                    error_count++;
                end
                else
                begin
                    want = expected_numbers.pop_front();
                    if (m_tuser[0] !== want.ok)
                    begin
                        if (error_count < REPORT_LIMIT)
                            $error("ok: expected %0d, actual %0d", want.ok, m_tuser[0]);
                        error_count++;
                    end
                    if (m_tdata !== want.value)
                    begin
                        if (error_count < REPORT_LIMIT)
                            $error("value: expected %0d, actual %0d",
                                   $signed(want.value), $signed(m_tdata));
                        error_count++;
                    end
                end
            end

            // Character beats; the terminator closes the string.
            if (s_tvalid && s_tready)
            begin
                if (s_tdata != CHAR_NUL)
                    take_char(s_tdata);
                else
                begin
                    expected_numbers.push_back(close_string());
                    clear_scan();
                end
            end

            open_results <= expected_numbers.size();
        end
    end

endmodule

[tb/sv/saturating_decimal_parser_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// saturating_decimal_parser_core_test: stimulus and verdict for the parser
// Streams directed and random strings into the parser with random gaps on
// both sides, one long result hold-off, and changes of narrow_to_32 while
// the parser is idle. A separate monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module saturating_decimal_parser_core_test;
    import sdp_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 5;
    localparam int QUIET_CYCLES    = 16;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 5000;
    localparam int PHASE_CHARS     = 280;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;   // [7:0] char_code
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [63:0] m_tdata;            // [63:0] value
    logic [0:0]  m_tuser;            // [0] ok
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data  = 1'b0;   // narrow_to_32

    int open_results;
    int error_count;
    int tx_idle_pct  = 29;
    int rx_idle_pct  = 63;
    bit hold_request = 1'b0;
    int quiet_count  = 0;

    always #(HALF_PERIOD) clk = ~clk;

    saturating_decimal_parser_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    saturating_decimal_parser_monitor i_monitor (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .open_results (open_results),
        .error_count  (error_count)
    );

    // Watchdog: ends the run when no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_count <= 0;
        else if (quiet_count >= STALL_LIMIT)
        begin
            $display("saturating_decimal_parser_core_test: done, errors");
            $finish;
        end
        else
            quiet_count <= quiet_count + 1;
    end

    // Result side: random back-pressure, plus one long hold-off on request.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_request = 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Offer one character beat, with random gaps before it.
    task automatic send_byte(input logic [7:0] code);
        begin
            while ($urandom_range(0, 99) < tx_idle_pct)
            begin
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= code;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
        end
    endtask

    task automatic send_string(input string text);
        int i;
        begin
            for (i = 0; i < text.len(); i++)
                send_byte(text.getc(i));
            send_byte(CHAR_NUL);
        end
    endtask

    // Drain all results, let the back end settle, then write narrow_to_32.
    task automatic write_narrow(input logic narrow);
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
            while (open_results != 0) @(posedge clk);
            repeat (QUIET_CYCLES) @(posedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= narrow;
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // Random strings: mostly numbers, some keywords, broken numbers and noise.
    task automatic run_random_phase(input int tx_pct, input int rx_pct,
                                    input logic narrow, input bit squeeze,
                                    input int budget);
        int          sent;
        int          kind;
        int          n;
        int          pos;
        logic [7:0]  word[$];
        string       kw;
        begin
            write_narrow(narrow);
            tx_idle_pct = tx_pct;
            rx_idle_pct = rx_pct;
            if (squeeze)
                hold_request = 1'b1;
            sent = 0;
            while (sent < budget)
            begin
                word.delete();
                kind = $urandom_range(0, 99);
                if (kind < 88 && !(kind >= 70 && kind < 78))
                begin
                    if ($urandom_range(0, 3) == 0)
                        word.push_back(CHAR_MINUS);
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22)
                                                     : $urandom_range(1, 6);
                    repeat (n) word.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                    if ($urandom_range(0, 1) != 0)
                    begin
                        word.push_back(CHAR_E);
                        n = $urandom_range(0, 3);
                        repeat (n)
                            word.push_back(($urandom_range(0, 2) == 0) ? CHAR_ZERO
                                           : CHAR_ZERO + 8'($urandom_range(1, 9)));
                    end
                    // Broken number: one character replaced by any nonzero byte.
                    if (kind >= 78)
                        word[$urandom_range(0, word.size() - 1)] = 8'($urandom_range(1, 255));
                end
                else if (kind < 78)
                begin
                    kw = ($urandom_range(0, 1) != 0) ? "true" : "false";
                    for (pos = 0; pos < kw.len(); pos++)
                        word.push_back(kw.getc(pos));
                    case ($urandom_range(0, 5))
                        0: void'(word.pop_back());
                        1: word.push_back(8'($urandom_range(1, 255)));
                        2: word[$urandom_range(0, word.size() - 1)] = 8'($urandom_range(1, 255));
                        default: ;
                    endcase
                end
                else
                begin
                    n = $urandom_range(0, 6);
                    repeat (n) word.push_back(8'($urandom_range(1, 255)));
                end
                for (pos = 0; pos < word.size(); pos++)
                    send_byte(word[pos]);
                send_byte(CHAR_NUL);
                sent += word.size() + 1;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed strings with full 64-bit results.
        write_narrow(1'b0);
        send_string("");
        send_string("-");
        send_string("true");
        send_string("false");
        send_string("tru");
        send_string("falsee");
        send_string("0");
        send_string("9223372036854775807");
        send_string("9223372036854775808");
        send_string("-9223372036854775808");
        send_string("-99999999999999999999");
        send_string("12e");
        send_string("7e3");
        send_string("1e05");
        send_string("1e50");
        send_string("-4e12");
        send_string("x12");
        send_string("1-2");
        send_string("e5");
        // Bytes with the top bit set are never digits.
        send_byte(8'hFF);
        send_byte(8'h80);
        send_byte(CHAR_NUL);
        send_byte("5");
        send_byte(8'hB9);
        send_byte(CHAR_NUL);

        // Directed strings around the 32-bit clamp.
        write_narrow(1'b1);
        send_string("2147483647");
        send_string("2147483648");
        send_string("-2147483648");
        send_string("-2147483649");
        send_string("1e9");

        run_random_phase(29, 63, 1'b0, 1'b0, PHASE_CHARS);
        run_random_phase(63, 29, 1'b1, 1'b0, PHASE_CHARS);
        run_random_phase(0, 0, 1'($urandom_range(0, 1)), 1'b1, PHASE_CHARS);

        // Wait for the last results and let the parser settle.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (open_results != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("saturating_decimal_parser_core_test: done, clean");
        else
            $display("saturating_decimal_parser_core_test: done, errors");
        $finish;
    end

endmodule
